// File: design/fixed_block_pool_allocator_top_defines.svh
// Assertion macros for the block pool allocator top level.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FBPA_ASSERT_IMP(name, a, c, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FBPA_ASSERT_NXT(name, a, c, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

// File: design/fbpa_pkg.sv
// Shared types, constants and helpers of the block pool allocator.
package fbpa_pkg;

    localparam int ADDR_W         = 32;
    localparam int SIZE_W         = 17;
    localparam int CNT_W          = 32;
    localparam int USE_W          = 7;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 32;
    localparam int NUM_BLOCKS_DEF = 64;
    localparam int CMDQ_DEPTH     = 2;
    localparam int CMDQ_PTR_W     = $clog2(CMDQ_DEPTH);

    localparam logic [ADDR_W-1:0]    POOL_BASE_RST  = '0;
    localparam logic [SIZE_W-1:0]    BLOCK_SIZE_RST = SIZE_W'(2048);

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = CFG_IDX_W'(1);

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_RANGE  = 2'd2;
    localparam logic [1:0] STATUS_DOUBLE = 2'd3;

    localparam int OP_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_RANGE
    } cmd_op_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SPAN,
        F_CHECK,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_MUL,
        B_ADD,
        B_FCHK,
        B_DONE
    } back_state_t;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] free_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        logic [1:0]        status;
        logic [CNT_W-1:0]  alloc_count;
        logic [CNT_W-1:0]  free_count;
        logic [USE_W-1:0]  blocks_in_use;
    } rsp_t;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size);
        return (size == '0) ? SIZE_W'(1) : size;
    endfunction

endpackage

// File: design/fixed_block_pool_allocator_top.sv
// Top level of the fixed-size block pool allocator.
//
// Requests come in on req (valid/ready): mode allocate or free, with the
// address to free. Each request gives exactly one item on rsp (valid/ready):
// block address, status and the allocation, free and held counts after it.
// The user writes pool_base and block_size through cfg_we/cfg_index/cfg_data
// only while no request is in flight; the block does not enforce this.
// Intake sends an allocate straight to F_PUSH. A free steps through F_SPAN
// and F_CHECK, then, if in range, through F_DIV, the divider for the block
// index with one quotient bit per cycle, and then to F_PUSH. The update side
// runs B_MUL, B_ADD and B_DONE for an allocate and B_FCHK and B_DONE for a
// free, after registered reads of the free list and flag memories; an allocate
// on a full pool or an out-of-range free goes straight to B_DONE.
// After reset the free list and in-use flags are swept, one entry a cycle;
// req_ready stays low during the sweep.
// A two-entry queue and the result register let intake keep accepting
// while rsp is stalled, until the queue fills.
`include "fixed_block_pool_allocator_top_defines.svh"

module fixed_block_pool_allocator_top #(
    parameter int NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  fbpa_pkg::req_t                     req,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output fbpa_pkg::rsp_t                     rsp,
    input  logic                               cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import fbpa_pkg::*;

    localparam int IDX_W  = $clog2(NUM_BLOCKS);
    localparam int CMD_W  = OP_W + IDX_W;

    logic [ADDR_W-1:0] pool_base_reg;
    logic [SIZE_W-1:0] block_size_reg;
    logic              clearing;
    logic              push_valid, push_ready, pop_valid, pop_ready;
    cmd_op_t           push_op, pop_op;
    logic [IDX_W-1:0]  push_idx, pop_idx;
    logic [CMD_W-1:0]  pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg  <= POOL_BASE_RST;
            block_size_reg <= BLOCK_SIZE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POOL_BASE:  pool_base_reg  <= ADDR_W'(cfg_data);
                CFG_BLOCK_SIZE: block_size_reg <= SIZE_W'(cfg_data);
                default:        pool_base_reg  <= pool_base_reg;
            endcase
        end
    end

    fbpa_front #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .pool_base  (pool_base_reg),
        .block_size (block_size_reg),
        .clearing   (clearing),
        .cmd_valid  (push_valid),
        .cmd_ready  (push_ready),
        .cmd_op     (push_op),
        .cmd_idx    (push_idx)
    );

    fbpa_cmd_fifo #(
        .WIDTH (CMD_W)
    ) u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_op, push_idx}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_op  = cmd_op_t'(pop_data[CMD_W-1:IDX_W]);
    assign pop_idx = pop_data[IDX_W-1:0];

    fbpa_back #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (pop_valid),
        .cmd_ready  (pop_ready),
        .cmd_op     (pop_op),
        .cmd_idx    (pop_idx),
        .pool_base  (pool_base_reg),
        .block_size (block_size_reg),
        .clearing   (clearing),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

    `FBPA_ASSERT_IMP(a_no_req_while_clearing, req_valid && req_ready, !clearing,
        "request accepted during the flag sweep")
    `FBPA_ASSERT_NXT(a_intake_one_at_a_time, req_valid && req_ready, !req_ready,
        "intake accepted a second item before finishing the first")
    `FBPA_ASSERT_IMP(a_fail_no_address, rsp_valid && (rsp.status != STATUS_OK),
        rsp.block_address == '0, "failed request returned a block address")
    `FBPA_ASSERT_IMP(a_full_means_all_held, rsp_valid && (rsp.status == STATUS_FULL),
        rsp.blocks_in_use == USE_W'(NUM_BLOCKS), "pool full while blocks remain free")

endmodule

// File: design/fbpa_front.sv
// Request intake: range check and block index division for frees.
module fbpa_front #(
    parameter int NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEF,
    parameter int IDX_W      = $clog2(NUM_BLOCKS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  fbpa_pkg::req_t                req,
    input  logic [fbpa_pkg::ADDR_W-1:0]   pool_base,
    input  logic [fbpa_pkg::SIZE_W-1:0]   block_size,
    input  logic                          clearing,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output fbpa_pkg::cmd_op_t             cmd_op,
    output logic [IDX_W-1:0]              cmd_idx
);
    import fbpa_pkg::*;

    localparam int SPAN_W = SIZE_W + IDX_W + 1;
    localparam int CMP_W  = (SPAN_W > ADDR_W) ? SPAN_W : ADDR_W;
    localparam int STEP_W = $clog2(IDX_W + 1);

    front_state_t        state_reg, state_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [SPAN_W-1:0]   span_reg, span_next;
    logic [ADDR_W-1:0]   off_reg, off_next;
    logic                below_reg, below_next;
    logic [CMP_W-1:0]    rem_reg, rem_next;
    logic [CMP_W-1:0]    div_reg, div_next;
    logic [IDX_W-1:0]    quot_reg, quot_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    cmd_op_t             op_reg, op_next;
    logic                rem_ge;

    assign rem_ge    = rem_reg >= div_reg;
    assign req_ready = (state_reg == F_IDLE) && !clearing;
    assign cmd_valid = (state_reg == F_PUSH);
    assign cmd_op    = op_reg;
    assign cmd_idx   = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        size_reg  <= size_next;
        span_reg  <= span_next;
        off_reg   <= off_next;
        below_reg <= below_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        quot_reg  <= quot_next;
        step_reg  <= step_next;
        op_reg    <= op_next;
    end

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        size_next  = size_reg;
        span_next  = span_reg;
        off_next   = off_reg;
        below_next = below_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        quot_next  = quot_reg;
        step_next  = step_reg;
        op_next    = op_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    addr_next = req.free_address;
                    size_next = eff_size(block_size);
                    if (req.mode == MODE_ALLOC)
                    begin
                        op_next    = OP_ALLOC;
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        state_next = F_SPAN;
                    end
                end
            end
            F_SPAN:
            begin
                span_next  = SPAN_W'(SPAN_W'(size_reg) * SPAN_W'(NUM_BLOCKS));
                below_next = addr_reg < pool_base;
                off_next   = addr_reg - pool_base;
                state_next = F_CHECK;
            end
            F_CHECK:
            begin
                if (below_reg || (CMP_W'(off_reg) >= CMP_W'(span_reg)))
                begin
                    op_next    = OP_RANGE;
                    state_next = F_PUSH;
                end
                else
                begin
                    rem_next   = CMP_W'(off_reg);
                    div_next   = CMP_W'(size_reg) << (IDX_W - 1);
                    quot_next  = '0;
                    step_next  = STEP_W'(IDX_W);
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                rem_next  = rem_ge ? (rem_reg - div_reg) : rem_reg;
                quot_next = (quot_reg << 1) | IDX_W'(rem_ge);
                div_next  = div_reg >> 1;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    op_next    = OP_FREE;
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (cmd_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

// File: design/fbpa_cmd_fifo.sv
// Short command queue between request intake and pool update.
module fbpa_cmd_fifo #(
    parameter int WIDTH = fbpa_pkg::OP_W + $clog2(fbpa_pkg::NUM_BLOCKS_DEF)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    import fbpa_pkg::*;

    logic [WIDTH-1:0]      entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_PTR_W:0]   count_reg, count_next;
    logic                  do_push, do_pop;

    assign push_ready = count_reg != (CMDQ_PTR_W + 1)'(CMDQ_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + CMDQ_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + CMDQ_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (CMDQ_PTR_W + 1)'(do_push) - (CMDQ_PTR_W + 1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/fbpa_back.sv
// Pool update: free list, in-use flags, counters and the result register.
module fbpa_back #(
    parameter int NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEF,
    parameter int IDX_W      = $clog2(NUM_BLOCKS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  fbpa_pkg::cmd_op_t             cmd_op,
    input  logic [IDX_W-1:0]              cmd_idx,
    input  logic [fbpa_pkg::ADDR_W-1:0]   pool_base,
    input  logic [fbpa_pkg::SIZE_W-1:0]   block_size,
    output logic                          clearing,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output fbpa_pkg::rsp_t                rsp
);
    import fbpa_pkg::*;

    localparam int NB_W   = $clog2(NUM_BLOCKS + 1);
    localparam int SUM_W  = NB_W + 1;
    localparam int PROD_W = SIZE_W + IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

    logic [IDX_W-1:0]  queue_mem [NUM_BLOCKS];
    logic              flag_mem  [NUM_BLOCKS];

    back_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  clr_idx_reg, clr_idx_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [NB_W-1:0]   fill_reg, fill_next;
    logic [NB_W-1:0]   held_reg, held_next;
    logic [CNT_W-1:0]  alloc_cnt_reg, alloc_cnt_next;
    logic [CNT_W-1:0]  free_cnt_reg, free_cnt_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [1:0]        pend_status_reg, pend_status_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;
    logic [IDX_W-1:0]  q_rd_reg;
    logic              f_rd_reg;

    logic              q_we, f_we, f_wdata;
    logic [IDX_W-1:0]  q_waddr, q_wdata, f_waddr, tail;
    logic [SUM_W-1:0]  tail_sum;
    logic [SIZE_W-1:0] size_eff;

    assign size_eff  = eff_size(block_size);
    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(fill_reg);
    assign tail      = (tail_sum >= SUM_W'(NUM_BLOCKS)) ?
                       IDX_W'(tail_sum - SUM_W'(NUM_BLOCKS)) : IDX_W'(tail_sum);
    assign clearing  = (state_reg == B_CLEAR);
    assign cmd_ready = (state_reg == B_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[q_waddr] <= q_wdata;
        end
        if (f_we)
        begin
            flag_mem[f_waddr] <= f_wdata;
        end
        q_rd_reg <= queue_mem[head_reg];
        f_rd_reg <= flag_mem[cmd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_idx_reg   <= '0;
            head_reg      <= '0;
            fill_reg      <= NB_W'(NUM_BLOCKS);
            held_reg      <= '0;
            alloc_cnt_reg <= '0;
            free_cnt_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            held_reg      <= held_next;
            alloc_cnt_reg <= alloc_cnt_next;
            free_cnt_reg  <= free_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        prod_reg        <= prod_next;
        pend_addr_reg   <= pend_addr_next;
        pend_status_reg <= pend_status_next;
        rsp_reg         <= rsp_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        head_next        = head_reg;
        fill_next        = fill_reg;
        held_next        = held_reg;
        alloc_cnt_next   = alloc_cnt_reg;
        free_cnt_next    = free_cnt_reg;
        idx_next         = idx_reg;
        prod_next        = prod_reg;
        pend_addr_next   = pend_addr_reg;
        pend_status_next = pend_status_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg;
        q_we             = 1'b0;
        q_waddr          = clr_idx_reg;
        q_wdata          = clr_idx_reg;
        f_we             = 1'b0;
        f_waddr          = clr_idx_reg;
        f_wdata          = 1'b0;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            B_CLEAR:
            begin
                q_we         = 1'b1;
                f_we         = 1'b1;
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    idx_next = cmd_idx;
                    case (cmd_op)
                        OP_ALLOC:
                        begin
                            if (fill_reg == '0)
                            begin
                                pend_addr_next   = '0;
                                pend_status_next = STATUS_FULL;
                                state_next       = B_DONE;
                            end
                            else
                            begin
                                state_next = B_MUL;
                            end
                        end
                        OP_FREE:
                        begin
                            state_next = B_FCHK;
                        end
                        default:
                        begin
                            pend_addr_next   = '0;
                            pend_status_next = STATUS_RANGE;
                            state_next       = B_DONE;
                        end
                    endcase
                end
            end
            B_MUL:
            begin
                prod_next      = PROD_W'(PROD_W'(q_rd_reg) * PROD_W'(size_eff));
                f_we           = 1'b1;
                f_waddr        = q_rd_reg;
                f_wdata        = 1'b1;
                head_next      = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
                fill_next      = fill_reg - NB_W'(1);
                held_next      = held_reg + NB_W'(1);
                alloc_cnt_next = alloc_cnt_reg + CNT_W'(1);
                state_next     = B_ADD;
            end
            B_ADD:
            begin
                pend_addr_next   = pool_base + ADDR_W'(prod_reg);
                pend_status_next = STATUS_OK;
                state_next       = B_DONE;
            end
            B_FCHK:
            begin
                pend_addr_next = '0;
                if (!f_rd_reg || (fill_reg >= NB_W'(NUM_BLOCKS)))
                begin
                    pend_status_next = STATUS_DOUBLE;
                end
                else
                begin
                    q_we             = 1'b1;
                    q_waddr          = tail;
                    q_wdata          = idx_reg;
                    f_we             = 1'b1;
                    f_waddr          = idx_reg;
                    f_wdata          = 1'b0;
                    fill_next        = fill_reg + NB_W'(1);
                    held_next        = held_reg - NB_W'(1);
                    free_cnt_next    = free_cnt_reg + CNT_W'(1);
                    pend_status_next = STATUS_OK;
                end
                state_next = B_DONE;
            end
            B_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.block_address = pend_addr_reg;
                    rsp_next.status        = pend_status_reg;
                    rsp_next.alloc_count   = alloc_cnt_reg;
                    rsp_next.free_count    = free_cnt_reg;
                    rsp_next.blocks_in_use = USE_W'(held_reg);
                    rsp_valid_next         = 1'b1;
                    state_next             = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

endmodule

// File: tb/fixed_block_pool_allocator_top_test.sv
// Self-checking testbench for the block pool allocator: randomized requests, predicted responses.
module fixed_block_pool_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fbpa_pkg::*;

    localparam int NBLK             = NUM_BLOCKS_DEF;
    localparam int IDX_W            = $clog2(NBLK);
    localparam int NUM_PHASES       = 9;
    localparam int RANDOM_PER_PHASE = 50;
    localparam int FILL_RUN         = NBLK + 2;
    localparam int HOLD_AT          = 100;
    localparam int HOLD_CYCLES      = 400;
    localparam int STALL_LIMIT      = 3000;
    localparam int DRAIN_CYCLES     = 40;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req       = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_POOL_BASE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    fixed_block_pool_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // pool state as the block should hold it
    logic [IDX_W-1:0]  fifo_slot [NBLK];
    logic [IDX_W-1:0]  fifo_head;
    logic [IDX_W:0]    fifo_count;
    logic              block_held [NBLK];
    logic [CNT_W-1:0]  allocs_done;
    logic [CNT_W-1:0]  frees_done;
    logic [USE_W-1:0]  held_now;
    logic [ADDR_W-1:0] base_reg;
    logic [SIZE_W-1:0] size_reg;

    req_t pending_reqs [$];
    rsp_t expected_rsps [$];

    int burst_left     = 0;
    int gap_left       = 0;
    int items_accepted = 0;
    int rsp_seen       = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int stall_tick     = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;
    int status_tally [4] = '{0, 0, 0, 0};

    task automatic pool_reset();
        for (int i = 0; i < NBLK; i++)
        begin
            fifo_slot[i]  = IDX_W'(i);
            block_held[i] = 1'b0;
        end
        fifo_head   = '0;
        fifo_count  = (IDX_W+1)'(NBLK);
        allocs_done = '0;
        frees_done  = '0;
        held_now    = '0;
        base_reg    = POOL_BASE_RST;
        size_reg    = BLOCK_SIZE_RST;
    endtask

    function automatic logic [63:0] block_span();
        return (size_reg == '0) ? 64'd1 : 64'(size_reg);
    endfunction

    function automatic rsp_t pool_request(req_t r);
        rsp_t             o;
        logic [63:0]      span;
        logic [63:0]      a;
        logic [63:0]      lim;
        logic [63:0]      blk;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] tail;
        o    = '0;
        span = block_span();
        if (r.mode == MODE_ALLOC)
        begin
            if (fifo_count == '0)
                o.status = STATUS_FULL;
            else
            begin
                idx             = fifo_slot[fifo_head];
                fifo_head       = fifo_head + IDX_W'(1);
                fifo_count      = fifo_count - (IDX_W+1)'(1);
                block_held[idx] = 1'b1;
                blk             = 64'(base_reg) + 64'(idx) * span;
                o.block_address = blk[ADDR_W-1:0];
                o.status        = STATUS_OK;
                allocs_done     = allocs_done + CNT_W'(1);
                held_now        = held_now + USE_W'(1);
            end
        end
        else
        begin
            a   = 64'(r.free_address);
            lim = 64'(base_reg) + span * 64'(NBLK);
            if (a < 64'(base_reg) || a >= lim)
                o.status = STATUS_RANGE;
            else
            begin
                blk = (a - 64'(base_reg)) / span;
                idx = blk[IDX_W-1:0];
                if (!block_held[idx] || fifo_count >= (IDX_W+1)'(NBLK))
                    o.status = STATUS_DOUBLE;
                else
                begin
                    tail            = fifo_head + fifo_count[IDX_W-1:0];
                    fifo_slot[tail] = idx;
                    fifo_count      = fifo_count + (IDX_W+1)'(1);
                    block_held[idx] = 1'b0;
                    frees_done      = frees_done + CNT_W'(1);
                    held_now        = held_now - USE_W'(1);
                    o.status        = STATUS_OK;
                end
            end
        end
        o.alloc_count   = allocs_done;
        o.free_count    = frees_done;
        o.blocks_in_use = held_now;
        return o;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // driver: bursts of items from the pending queue, random gaps between bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                expected_rsps.push_back(pool_request(req));
                items_accepted++;
            end
            if (!req_valid || req_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each response item, drives rsp_ready on its own pattern
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                rsp_seen++;
                status_tally[rsp.status]++;
                if (expected_rsps.size() == 0)
                begin
                    $error("response item with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    check_field("block_address", 64'(want.block_address), 64'(rsp.block_address));
                    check_field("status", 64'(want.status), 64'(rsp.status));
                    check_field("alloc_count", 64'(want.alloc_count), 64'(rsp.alloc_count));
                    check_field("free_count", 64'(want.free_count), 64'(rsp.free_count));
                    check_field("blocks_in_use", 64'(want.blocks_in_use),
                                64'(rsp.blocks_in_use));
                end
            end
            stall_tick++;
            if (!hold_done && rsp_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                case ((stall_tick / 256) % 4)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ready <= (stall_tick % 3 == 0);
                    default: rsp_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_POOL_BASE)
            base_reg = val;
        else
            size_reg = val[SIZE_W-1:0];
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
            @(posedge clk);
    endtask

    task automatic push_alloc();
        req_t r;
        r.mode         = MODE_ALLOC;
        r.free_address = $urandom();
        pending_reqs.push_back(r);
    endtask

    task automatic push_free(logic [ADDR_W-1:0] a);
        req_t r;
        r.mode         = MODE_FREE;
        r.free_address = a;
        pending_reqs.push_back(r);
    endtask

    // mostly addresses inside the pool, some at the edges and some anywhere
    function automatic logic [ADDR_W-1:0] pick_free_addr(bit in_pool);
        logic [63:0] span;
        logic [63:0] a;
        int unsigned sel;
        span = block_span();
        sel  = in_pool ? 9 : $urandom_range(0, 9);
        case (sel)
            0: a = 64'($urandom());
            1: a = 64'(base_reg) - 64'd1;
            2: a = 64'(base_reg) + span * 64'(NBLK);
            3: a = 64'(base_reg) + span * 64'(NBLK) - 64'd1;
            default:
            begin
                a = 64'(base_reg) + span * 64'($urandom_range(0, NBLK - 1));
                if ($urandom_range(0, 1) == 1)
                    a = a + 64'($urandom_range(0, 32'(span - 64'd1)));
            end
        endcase
        return a[ADDR_W-1:0];
    endfunction

    task automatic queue_mix(int n);
        int left;
        int run;
        left = n;
        while (left > 0)
        begin
            run = $urandom_range(1, 6);
            if (run > left)
                run = left;
            left -= run;
            if ($urandom_range(0, 1) == 1)
                repeat (run) push_alloc();
            else
                repeat (run) push_free(pick_free_addr(1'b0));
        end
    endtask

    // exhaust the pool, then free into the empty list and allocate again
    task automatic queue_fill_and_refill();
        repeat (FILL_RUN) push_alloc();
        repeat (4)
        begin
            push_free(pick_free_addr(1'b1));
            push_alloc();
            push_alloc();
        end
    endtask

    initial
    begin
        logic [ADDR_W-1:0] pb;
        logic [SIZE_W-1:0] bs;
        pool_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);

        write_reg(CFG_POOL_BASE, 32'h0);
        write_reg(CFG_BLOCK_SIZE, 32'd2048);
        push_free(32'h0000_0000);
        push_free(32'h0002_0000);
        push_free(32'hFFFF_FFFF);
        push_free(32'h0001_FFFF);
        push_alloc();
        push_alloc();
        push_free(32'h0000_0FFF);
        push_free(32'h0000_0800);
        push_free(32'h0000_03E8);
        push_alloc();
        push_free(32'h0000_0000);
        queue_mix(RANDOM_PER_PHASE);
        wait_drained();

        for (int p = 1; p < NUM_PHASES; p++)
        begin
            case (p)
                1:
                begin
                    pb = 32'hFFFF_FC00;
                    bs = 17'd64;
                end
                2:
                begin
                    pb = 32'h0000_1000;
                    bs = 17'd0;
                end
                3:
                begin
                    pb = 32'hFFC0_0000;
                    bs = 17'h10000;
                end
                4:
                begin
                    pb = 32'hFFFF_FFFF;
                    bs = 17'd1;
                end
                5:
                begin
                    pb = 32'h0000_0000;
                    bs = 17'd1;
                end
                6:
                begin
                    pb = 32'h0001_2345;
                    bs = 17'd24;
                end
                7:
                begin
                    pb = $urandom();
                    bs = SIZE_W'($urandom_range(1, 65536));
                end
                default:
                begin
                    pb = 32'h00FF_0000;
                    bs = 17'h0FFFF;
                end
            endcase
            if ($urandom_range(0, 1) == 1)
            begin
                write_reg(CFG_POOL_BASE, pb);
                write_reg(CFG_BLOCK_SIZE, CFG_DATA_W'(bs));
            end
            else
            begin
                write_reg(CFG_BLOCK_SIZE, CFG_DATA_W'(bs));
                write_reg(CFG_POOL_BASE, pb);
            end
            if (p % 2 == 1)
                queue_fill_and_refill();
            queue_mix(RANDOM_PER_PHASE);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_rsps.size() != 0)
        begin
            $error("%0d expected response items never arrived", expected_rsps.size());
            mismatches++;
        end
        $display("%0d requests over %0d pool settings, %0d responses checked, %0d mismatches",
                 items_accepted, NUM_PHASES, rsp_seen, mismatches);
        $display("responses: %0d ok, %0d pool full, %0d out of range, %0d double free",
                 status_tally[STATUS_OK], status_tally[STATUS_FULL],
                 status_tally[STATUS_RANGE], status_tally[STATUS_DOUBLE]);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
